[hdl/hte_pkg.sv]
// Shared types, constants and the control-store contents of the HTML text escaper.
package hte_pkg;

   localparam int LINE_DIGITS_DEF = 8;
   localparam int MAX_TAB_DEF     = 10;

   localparam int BYTE_W     = 8;
   localparam int TAB_W      = 4;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam int PC_W       = 6;

   // Configuration register indices
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_WIDTH    = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_LINES = 8'd1;

   localparam logic [TAB_W-1:0] TAB_DEFAULT = 4'd4;

   // Routine entry points in the control store
   localparam logic [PC_W-1:0] PC_QUOT  = 6'd0;
   localparam logic [PC_W-1:0] PC_APOS  = 6'd6;
   localparam logic [PC_W-1:0] PC_AMP   = 6'd12;
   localparam logic [PC_W-1:0] PC_LT    = 6'd17;
   localparam logic [PC_W-1:0] PC_GT    = 6'd21;
   localparam logic [PC_W-1:0] PC_NBSP  = 6'd25;
   localparam logic [PC_W-1:0] PC_BR    = 6'd31;
   localparam logic [PC_W-1:0] PC_PASS  = 6'd36;
   localparam logic [PC_W-1:0] PC_NUM   = 6'd37;

   typedef enum logic [2:0] {
      OP_NEXT  = 3'd0,  // emit literal, step on
      OP_END   = 3'd1,  // emit literal, close the run
      OP_PASS  = 3'd2,  // emit the held input byte, close the run
      OP_TAB   = 3'd3,  // emit literal, repeat the &nbsp; routine while count remains
      OP_NL    = 3'd4,  // emit literal, branch to the number routine when numbering
      OP_DIGIT = 3'd5,  // emit one line-number digit, repeat down to digit zero
      OP_RET   = 3'd6   // emit literal, advance the counter, return or close
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [BYTE_W-1:0] ch;
   } ctl_word_type;

   function automatic ctl_word_type hte_cw(input op_type op, input logic [BYTE_W-1:0] ch);
      ctl_word_type w;
      w.op = op;
      w.ch = ch;
      return w;
   endfunction

   function automatic ctl_word_type hte_rom(input logic [PC_W-1:0] pc);
      ctl_word_type w;
      case (pc)
         6'd0:  w = hte_cw(OP_NEXT,  "&");
         6'd1:  w = hte_cw(OP_NEXT,  "q");
         6'd2:  w = hte_cw(OP_NEXT,  "u");
         6'd3:  w = hte_cw(OP_NEXT,  "o");
         6'd4:  w = hte_cw(OP_NEXT,  "t");
         6'd5:  w = hte_cw(OP_END,   ";");
         6'd6:  w = hte_cw(OP_NEXT,  "&");
         6'd7:  w = hte_cw(OP_NEXT,  "a");
         6'd8:  w = hte_cw(OP_NEXT,  "p");
         6'd9:  w = hte_cw(OP_NEXT,  "o");
         6'd10: w = hte_cw(OP_NEXT,  "s");
         6'd11: w = hte_cw(OP_END,   ";");
         6'd12: w = hte_cw(OP_NEXT,  "&");
         6'd13: w = hte_cw(OP_NEXT,  "a");
         6'd14: w = hte_cw(OP_NEXT,  "m");
         6'd15: w = hte_cw(OP_NEXT,  "p");
         6'd16: w = hte_cw(OP_END,   ";");
         6'd17: w = hte_cw(OP_NEXT,  "&");
         6'd18: w = hte_cw(OP_NEXT,  "l");
         6'd19: w = hte_cw(OP_NEXT,  "t");
         6'd20: w = hte_cw(OP_END,   ";");
         6'd21: w = hte_cw(OP_NEXT,  "&");
         6'd22: w = hte_cw(OP_NEXT,  "g");
         6'd23: w = hte_cw(OP_NEXT,  "t");
         6'd24: w = hte_cw(OP_END,   ";");
         6'd25: w = hte_cw(OP_NEXT,  "&");
         6'd26: w = hte_cw(OP_NEXT,  "n");
         6'd27: w = hte_cw(OP_NEXT,  "b");
         6'd28: w = hte_cw(OP_NEXT,  "s");
         6'd29: w = hte_cw(OP_NEXT,  "p");
         6'd30: w = hte_cw(OP_TAB,   ";");
         6'd31: w = hte_cw(OP_NEXT,  "<");
         6'd32: w = hte_cw(OP_NEXT,  "b");
         6'd33: w = hte_cw(OP_NEXT,  "r");
         6'd34: w = hte_cw(OP_NEXT,  ">");
         6'd35: w = hte_cw(OP_NL,    8'h0A);
         6'd36: w = hte_cw(OP_PASS,  8'h00);
         6'd37: w = hte_cw(OP_DIGIT, 8'h00);
         6'd38: w = hte_cw(OP_NEXT,  ":");
         6'd39: w = hte_cw(OP_RET,   " ");
         default: w = hte_cw(OP_PASS, 8'h00);
      endcase
      return w;
   endfunction

   // Routine that handles a given source byte
   function automatic logic [PC_W-1:0] hte_entry(input logic [BYTE_W-1:0] b);
      logic [PC_W-1:0] pc;
      case (b)
         8'h22:   pc = PC_QUOT;
         8'h27:   pc = PC_APOS;
         8'h26:   pc = PC_AMP;
         8'h3C:   pc = PC_LT;
         8'h3E:   pc = PC_GT;
         8'h20:   pc = PC_NBSP;
         8'h09:   pc = PC_NBSP;
         8'h0A:   pc = PC_BR;
         default: pc = PC_PASS;
      endcase
      return pc;
   endfunction

endpackage

[hdl/hte_line_counter.sv]
// BCD line counter: saturating increment, digit read-out and leading-digit search.
module hte_line_counter import hte_pkg::*; #(
   parameter int LINE_DIGITS = LINE_DIGITS_DEF,
   localparam int IDX_W = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [3:0]       rd_digit,
   output logic [IDX_W-1:0] top_idx
);

   logic [3:0] digit_ff [LINE_DIGITS];
   logic [3:0] digit_in [LINE_DIGITS];
   logic       all_nines;
   logic       carry;

   assign rd_digit = digit_ff[rd_idx];

   always_comb begin
      top_idx = '0;
      for (int k = 0; k < LINE_DIGITS; k++) begin
         if (digit_ff[k] != 4'd0) begin
            top_idx = IDX_W'(k);
         end
      end
   end

   // Ripple the carry through the digits; hold at all nines
   always_comb begin
      all_nines = 1'b1;
      carry     = 1'b1;
      for (int k = 0; k < LINE_DIGITS; k++) begin
         if (digit_ff[k] != 4'd9) begin
            all_nines = 1'b0;
         end
      end
      for (int k = 0; k < LINE_DIGITS; k++) begin
         digit_in[k] = digit_ff[k];
         if (advance && !all_nines && carry) begin
            if (digit_ff[k] == 4'd9) begin
               digit_in[k] = 4'd0;
            end else begin
               digit_in[k] = digit_ff[k] + 4'd1;
               carry       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LINE_DIGITS; k++) begin
            digit_ff[k] <= (k == 0) ? 4'd1 : 4'd0;
         end
      end else begin
         digit_ff <= digit_in;
      end
   end

endmodule

[hdl/html_text_escaper_unit.sv]
// Top level of the HTML text escaper: microcoded sequencer, output register, config port.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_in_byte
//  rsp     | out       | rsp_valid / rsp_ready | rsp_out_byte, rsp_last_of_run
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// One transaction in flight at a time: the sequencer takes one control-store step per
// output byte, and the next transaction is taken only once the current run is closed.
// Output stalls hold the sequencer in place.
// Synchronous reset clears control state and sets the line number to one; no clearing pass.
// The config port is always ready.
module html_text_escaper_unit import hte_pkg::*; #(
   parameter int LINE_DIGITS = LINE_DIGITS_DEF,
   parameter int MAX_TAB     = MAX_TAB_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [BYTE_W-1:0]     req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [BYTE_W-1:0]     rsp_out_byte,
   output logic                  rsp_last_of_run,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (LINE_DIGITS > 1) ? $clog2(LINE_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_TAB + 1);

   logic                 busy_ff, busy_in;
   logic                 started_ff, started_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [PC_W-1:0]      ret_pc_ff, ret_pc_in;
   logic                 ret_end_ff, ret_end_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BYTE_W-1:0]    byte_ff, byte_in;
   logic                 rv_ff, rv_in;
   logic [BYTE_W-1:0]    rb_ff, rb_in;
   logic                 rl_ff, rl_in;
   logic [TAB_W-1:0]     tab_width_ff;
   logic                 number_lines_ff;

   ctl_word_type         cw;
   logic                 accept, step, advance;
   logic [3:0]           digit;
   logic [IDX_W-1:0]     top_idx;
   logic [TAB_W-1:0]     tab_eff;
   logic [PC_W-1:0]      entry_pc;

   hte_line_counter #(.LINE_DIGITS(LINE_DIGITS)) u_line (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .rd_idx   (idx_ff),
      .rd_digit (digit),
      .top_idx  (top_idx)
   );

   assign req_ready       = !busy_ff;
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rv_ff;
   assign rsp_out_byte    = rb_ff;
   assign rsp_last_of_run = rl_ff;

   assign accept   = req_valid && !busy_ff;
   assign step     = busy_ff && (!rv_ff || rsp_ready);
   assign cw       = hte_rom(pc_ff);
   assign entry_pc = hte_entry(req_in_byte);

   always_comb begin
      tab_eff = (tab_width_ff == '0) ? TAB_DEFAULT : tab_width_ff;
      if (tab_eff > TAB_W'(MAX_TAB)) begin
         tab_eff = TAB_W'(MAX_TAB);
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      started_in = started_ff;
      pc_in      = pc_ff;
      ret_pc_in  = ret_pc_ff;
      ret_end_in = ret_end_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      byte_in    = byte_ff;
      rv_in      = rv_ff && !rsp_ready;
      rb_in      = rb_ff;
      rl_in      = rl_ff;
      advance    = 1'b0;

      if (accept) begin
         busy_in    = 1'b1;
         started_in = 1'b1;
         byte_in    = req_in_byte;
         cnt_in     = (req_in_byte == 8'h09) ? CNT_W'(tab_eff) : CNT_W'(1);
         // Prefix the very first line with its number before the byte's own output
         if (!started_ff && number_lines_ff) begin
            pc_in      = PC_NUM;
            idx_in     = top_idx;
            ret_pc_in  = entry_pc;
            ret_end_in = 1'b0;
         end else begin
            pc_in = entry_pc;
         end
      end

      if (step) begin
         rv_in = 1'b1;
         rl_in = 1'b0;
         rb_in = cw.ch;
         case (cw.op)
            OP_NEXT: begin
               pc_in = pc_ff + PC_W'(1);
            end
            OP_END: begin
               rl_in   = 1'b1;
               busy_in = 1'b0;
            end
            OP_PASS: begin
               rb_in   = byte_ff;
               rl_in   = 1'b1;
               busy_in = 1'b0;
            end
            OP_TAB: begin
               if (cnt_ff > CNT_W'(1)) begin
                  cnt_in = cnt_ff - CNT_W'(1);
                  pc_in  = PC_NBSP;
               end else begin
                  rl_in   = 1'b1;
                  busy_in = 1'b0;
               end
            end
            OP_NL: begin
               if (number_lines_ff) begin
                  pc_in      = PC_NUM;
                  idx_in     = top_idx;
                  ret_end_in = 1'b1;
               end else begin
                  rl_in   = 1'b1;
                  busy_in = 1'b0;
               end
            end
            OP_DIGIT: begin
               rb_in = {4'h3, digit};
               if (idx_ff != '0) begin
                  idx_in = idx_ff - IDX_W'(1);
               end else begin
                  pc_in = pc_ff + PC_W'(1);
               end
            end
            OP_RET: begin
               advance = 1'b1;
               if (ret_end_ff) begin
                  rl_in   = 1'b1;
                  busy_in = 1'b0;
               end else begin
                  pc_in = ret_pc_ff;
               end
            end
            default: begin
               rl_in   = 1'b1;
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         started_ff      <= 1'b0;
         rv_ff           <= 1'b0;
         tab_width_ff    <= '0;
         number_lines_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         started_ff <= started_in;
         rv_ff      <= rv_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_TAB_WIDTH:    tab_width_ff    <= csr_wdata[TAB_W-1:0];
               CSR_NUMBER_LINES: number_lines_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pc_ff      <= pc_in;
      ret_pc_ff  <= ret_pc_in;
      ret_end_ff <= ret_end_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      byte_ff    <= byte_in;
      rb_ff      <= rb_in;
      rl_ff      <= rl_in;
   end

endmodule

[hdl/hte_checker.sv]
// Port-level checks for the HTML text escaper and their binding to the top level.
module hte_checker import hte_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_last_of_run
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // Only one transaction is worked on at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a run is in progress");

   // While idle, no unfinished run can be showing
   a_idle_run_closed: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(rsp_valid && !rsp_last_of_run))
      else $error("open run while idle");

   // Idle with nothing showing: no result can appear on the next cycle
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result raised with no transaction in flight");

endmodule

bind html_text_escaper_unit hte_checker u_hte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

[tb/html_text_escaper_unit_test.sv]
// Self-checking testbench for the HTML text escaper: randomised byte stream against a predictor.
module html_text_escaper_unit_test;
   import hte_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_DIGITS  = LINE_DIGITS_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE      = 8;

   localparam logic [BYTE_W-1:0] CH_TAB  = 8'h09;
   localparam logic [BYTE_W-1:0] CH_NL   = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
   localparam logic [BYTE_W-1:0] CH_QUOT = 8'h22;
   localparam logic [BYTE_W-1:0] CH_AMP  = 8'h26;
   localparam logic [BYTE_W-1:0] CH_APOS = 8'h27;
   localparam logic [BYTE_W-1:0] CH_LT   = 8'h3C;
   localparam logic [BYTE_W-1:0] CH_GT   = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

   typedef struct packed {
      logic [BYTE_W-1:0] ch;
      logic              last;
   } out_beat_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_in_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic                  rsp_last_of_run;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state and configuration
   logic [3:0]       line_bcd [NUM_DIGITS];
   bit               seen_first;
   logic [TAB_W-1:0] cfg_tab;
   bit               cfg_number;

   logic [BYTE_W-1:0] byte_q [$];
   logic [BYTE_W-1:0] run_q [$];
   out_beat_type      escaped_q [$];

   int mismatches = 0;
   int req_gap = 0;
   int rsp_gap = 0;
   bit drv_calm = 1'b0;
   bit mon_calm = 1'b0;
   int stall_cycles = 0;

   html_text_escaper_unit #(.LINE_DIGITS(NUM_DIGITS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) run_q.push_back(s[i]);
   endfunction

   function automatic void emit_line_number();
      int  top;
      int  k;
      bit  all_nines;
      bit  carry;
      top = 0;
      for (k = 0; k < NUM_DIGITS; k++)
         if (line_bcd[k] != 4'd0) top = k;
      for (k = top; k >= 0; k--) run_q.push_back(CH_ZERO | {4'h0, line_bcd[k]});
      push_text(": ");
      all_nines = 1'b1;
      for (k = 0; k < NUM_DIGITS; k++)
         if (line_bcd[k] != 4'd9) all_nines = 1'b0;
      // hold at all nines, otherwise ripple the BCD increment
      if (!all_nines) begin
         carry = 1'b1;
         for (k = 0; k < NUM_DIGITS; k++) begin
            if (carry) begin
               if (line_bcd[k] == 4'd9) begin
                  line_bcd[k] = 4'd0;
               end else begin
                  line_bcd[k] = line_bcd[k] + 4'd1;
                  carry = 1'b0;
               end
            end
         end
      end
   endfunction

   function automatic void escape_byte(input logic [BYTE_W-1:0] c);
      int           n;
      int           k;
      out_beat_type beat;
      run_q.delete();
      if (!seen_first) begin
         seen_first = 1'b1;
         if (cfg_number) emit_line_number();
      end
      case (c)
         CH_QUOT: push_text("&quot;");
         CH_APOS: push_text("&apos;");
         CH_AMP:  push_text("&amp;");
         CH_LT:   push_text("&lt;");
         CH_GT:   push_text("&gt;");
         CH_SP:   push_text("&nbsp;");
         CH_TAB: begin
            n = (cfg_tab == 0) ? int'(TAB_DEFAULT) : int'(cfg_tab);
            if (n > MAX_TAB_DEF) n = MAX_TAB_DEF;
            for (k = 0; k < n; k++) push_text("&nbsp;");
         end
         CH_NL: begin
            push_text("<br>\n");
            if (cfg_number) emit_line_number();
         end
         default: run_q.push_back(c);
      endcase
      for (k = 0; k < run_q.size(); k++) begin
         beat.ch   = run_q[k];
         beat.last = (k == run_q.size() - 1);
         escaped_q.push_back(beat);
      end
   endfunction

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : int'($urandom_range(0, 17));
   endfunction

   function automatic logic [BYTE_W-1:0] random_source_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 22) return CH_NL;
      if (r < 30) return CH_TAB;
      if (r < 48) begin
         case ($urandom_range(0, 5))
            0: return CH_QUOT;
            1: return CH_APOS;
            2: return CH_AMP;
            3: return CH_LT;
            4: return CH_GT;
            default: return CH_SP;
         endcase
      end
      if (r < 80) return 8'($urandom_range(8'h21, 8'h7E));
      return 8'($urandom_range(0, 255));
   endfunction

   // driver: present the pending bytes, with a drawn gap after each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) escape_byte(req_in_byte);
         if (req_valid && !req_ready) begin
            // hold the transaction until it is taken
         end else if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (byte_q.size() != 0) begin
            req_valid   <= 1'b1;
            req_in_byte <= byte_q.pop_front();
            req_gap     <= draw_gap(drv_calm);
            if ($urandom_range(0, 29) == 0) drv_calm <= ~drv_calm;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: check each output transaction, then back off for a drawn stall
   always @(posedge clock) begin
      int           w;
      out_beat_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (escaped_q.size() == 0) begin
            mismatches <= mismatches + 1;
            $display("%0t: unexpected output: expected nothing, actual byte %h last %b",
                     $time, rsp_out_byte, rsp_last_of_run);
         end else begin
            want = escaped_q.pop_front();
            if (want.ch !== rsp_out_byte || want.last !== rsp_last_of_run) begin
               mismatches <= mismatches + 1;
               $display("%0t: output mismatch: expected byte %h last %b, actual byte %h last %b",
                        $time, want.ch, want.last, rsp_out_byte, rsp_last_of_run);
            end
         end
         w = draw_gap(mon_calm);
         if ($urandom_range(0, 29) == 0) mon_calm <= ~mon_calm;
         if (w > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap   <= w - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end else if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
               $display("html_text_escaper_unit_test: done, errors");
               $finish;
            end
         end
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TAB_WIDTH:    cfg_tab = data[TAB_W-1:0];
         CSR_NUMBER_LINES: cfg_number = data[0];
         default: ;
      endcase
   endtask

   task automatic wait_drain();
      do @(negedge clock); while (byte_q.size() != 0 || req_valid || escaped_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      int                    i;
      int                    p;
      int                    count;
      string                 text;
      logic [CSR_DATA_W-1:0] wd;
      for (i = 0; i < NUM_DIGITS; i++) line_bcd[i] = 4'd0;
      line_bcd[0] = 4'd1;
      seen_first = 1'b0;
      cfg_tab    = '0;
      cfg_number = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // numbering on for the very first byte, default tab
      write_csr(CSR_TAB_WIDTH, 8'h00);
      write_csr(CSR_NUMBER_LINES, 8'h01);
      @(negedge clock);
      text = "A\"'&<> \t\n";
      for (i = 0; i < text.len(); i++) byte_q.push_back(text[i]);
      byte_q.push_back(8'h00);
      byte_q.push_back(8'hFF);
      byte_q.push_back(8'h7F);
      byte_q.push_back(8'h80);
      byte_q.push_back(CH_NL);
      wait_drain();

      // widest tab, numbering off
      write_csr(CSR_TAB_WIDTH, 8'h0A);
      write_csr(CSR_NUMBER_LINES, 8'h00);
      @(negedge clock);
      text = "\t\t \nq";
      for (i = 0; i < text.len(); i++) byte_q.push_back(text[i]);
      wait_drain();

      // oversize tab saturates, unknown index dropped, upper data bits ignored
      write_csr(CSR_TAB_WIDTH, 8'hFF);
      write_csr(8'hFF, 8'h5A);
      write_csr(CSR_NUMBER_LINES, 8'hFF);
      @(negedge clock);
      byte_q.push_back(CH_TAB);
      byte_q.push_back(CH_NL);
      wait_drain();

      write_csr(CSR_TAB_WIDTH, 8'hF1);
      @(negedge clock);
      text = "\tx\n";
      for (i = 0; i < text.len(); i++) byte_q.push_back(text[i]);
      wait_drain();

      // short numbered lines: carry the counter into its second digit
      write_csr(CSR_NUMBER_LINES, 8'h01);
      @(negedge clock);
      count = 0;
      while (count < 60) begin
         repeat ($urandom_range(0, 2)) begin
            byte_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
            count++;
         end
         byte_q.push_back(CH_NL);
         count++;
      end
      wait_drain();

      for (p = 0; p < 11; p++) begin
         if ($urandom_range(0, 3) != 0) begin
            wd = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 4))
               0: wd[3:0] = 4'd0;
               1: wd[3:0] = 4'd10;
               2: wd[3:0] = 4'd15;
               3: wd[3:0] = 4'd1;
               default: ;
            endcase
            write_csr(CSR_TAB_WIDTH, wd);
         end
         if ($urandom_range(0, 3) == 0)
            write_csr(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
         if ($urandom_range(0, 3) != 0) begin
            wd    = 8'($urandom_range(0, 255));
            wd[0] = ($urandom_range(0, 3) != 0);
            write_csr(CSR_NUMBER_LINES, wd);
         end
         @(negedge clock);
         for (i = 0; i < 28; i++) byte_q.push_back(random_source_byte());
         wait_drain();
      end

      if (mismatches == 0 && escaped_q.size() == 0) begin
         $display("html_text_escaper_unit_test: done, clean");
      end else begin
         $display("html_text_escaper_unit_test: done, errors");
      end
      $finish;
   end

endmodule
